@@ design/rsb_pkg.sv @@
package rsb_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] RESET_BACKOFF_BASE = 32'd100;
  localparam logic [31:0] RESET_BACKOFF_MAX = 32'd6400;
  localparam logic [31:0] RESET_STABLE_TICKS = 32'd10000;
  localparam logic [7:0] RESET_MAX_ATTEMPTS = 8'd10;

  typedef enum logic [2:0] {
    CMD_EVALUATE = 3'd0,
    CMD_DECLARE = 3'd1,
    CMD_REDECLARE = 3'd2,
    CMD_CLEAR_GIVE_UP = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_START = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_STOP = 3'd3,
    ACT_GAVE_UP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    POL_NEVER = 2'd0,
    POL_ON_FAILURE = 2'd1,
    POL_ALWAYS = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    CST_RUNNING = 2'd0,
    CST_HALTED = 2'd1,
    CST_TRAPPED = 2'd2,
    CST_UNKNOWN = 2'd3
  } cst_t;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_BACKOFF_BASE = 3'd1,
    REG_BACKOFF_MAX = 3'd2,
    REG_STABLE_RESET = 3'd3,
    REG_MAX_ATTEMPTS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic enable;
    logic [31:0] backoff_base_ticks;
    logic [31:0] backoff_max_ticks;
    logic [31:0] stable_reset_ticks;
    logic [7:0] max_attempts;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic desired_running;
    logic [1:0] policy;
    logic has_program;
    logic [7:0] retry_count;
    logic [31:0] retry_total;
    logic [63:0] last_restart;
    logic [63:0] started_at;
    logic gave_up;
    logic converged;
  } entry_t;

endpackage

@@ design/rsb_cfg.sv @@
module rsb_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output rsb_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.backoff_base_ticks <= rsb_pkg::RESET_BACKOFF_BASE;
      cfg.backoff_max_ticks <= rsb_pkg::RESET_BACKOFF_MAX;
      cfg.stable_reset_ticks <= rsb_pkg::RESET_STABLE_TICKS;
      cfg.max_attempts <= rsb_pkg::RESET_MAX_ATTEMPTS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsb_pkg::REG_ENABLE: cfg.enable <= cfg_data[0];
        rsb_pkg::REG_BACKOFF_BASE: cfg.backoff_base_ticks <= cfg_data;
        rsb_pkg::REG_BACKOFF_MAX: cfg.backoff_max_ticks <= cfg_data;
        rsb_pkg::REG_STABLE_RESET: cfg.stable_reset_ticks <= cfg_data;
        rsb_pkg::REG_MAX_ATTEMPTS: cfg.max_attempts <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/rsb_ctrl.sv @@
module rsb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output rsb_pkg::ctrl_cmd_t ctl
);

  rsb_pkg::state_t state;
  rsb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsb_pkg::ST_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= ctl.commit;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = 1'b1;
    unique case (state)
      rsb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          state_next = rsb_pkg::ST_READ;
        end
      end
      rsb_pkg::ST_READ: begin
        ctl.capture = 1'b1;
        state_next = rsb_pkg::ST_EXEC;
      end
      rsb_pkg::ST_EXEC: begin
        ctl.commit = 1'b1;
        state_next = rsb_pkg::ST_IDLE;
      end
      default: state_next = rsb_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/rsb_dpath.sv @@
module rsb_dpath (
  input  logic clk,
  input  logic rst,
  input  rsb_pkg::ctrl_cmd_t ctl,
  input  rsb_pkg::cfg_t cfg,
  input  logic [2:0] command,
  input  logic [3:0] slot,
  input  logic [63:0] now_tick,
  input  logic desired_run,
  input  logic [1:0] policy,
  input  logic has_program,
  input  logic context_live,
  input  logic [1:0] context_status,
  input  logic partition_present,
  output logic [2:0] action,
  output logic status,
  output logic [7:0] restart_count_out,
  output logic [31:0] restarts_total_out,
  output logic gave_up_out,
  output logic converged_out
);

  rsb_pkg::entry_t mem [rsb_pkg::SLOTS];
  logic [rsb_pkg::SLOTS-1:0] active;

  logic [2:0] req_cmd;
  logic [rsb_pkg::SLOT_W-1:0] req_idx;
  logic req_in_range;
  logic [63:0] req_now;
  logic req_want;
  logic [1:0] req_policy;
  logic req_prog;
  logic req_live;
  logic [1:0] req_cst;
  logic req_part;

  rsb_pkg::entry_t rd_entry;
  rsb_pkg::entry_t ent;
  logic ent_active;
  logic [31:0] wait_ticks;
  logic [63:0] age_last;
  logic [63:0] age_start;

  logic [31:0] wait_next;
  logic [63:0] shifted;
  logic [4:0] shamt;
  logic [63:0] age_last_next;
  logic [63:0] age_start_next;

  rsb_pkg::entry_t ent_next;
  logic mem_we;
  logic set_active;
  logic clr_active;
  logic [2:0] action_next;
  logic status_next;
  logic report;
  logic took;
  logic failure;
  logic wants_restart;
  logic backoff_ok;
  logic stable_ok;

  // The backoff doubles from the base per restart after the first, up to the cap.
  always_comb begin
    shamt = (rd_entry.retry_count <= 8'd1) ? 5'd0 : 5'(rd_entry.retry_count - 8'd1);
    shifted = {32'd0, cfg.backoff_base_ticks} << shamt;
    if (cfg.backoff_base_ticks == 32'd0) begin
      wait_next = 32'd0;
    end else if (rd_entry.retry_count > 8'd32) begin
      wait_next = cfg.backoff_max_ticks;
    end else if (shifted > {32'd0, cfg.backoff_max_ticks}) begin
      wait_next = cfg.backoff_max_ticks;
    end else begin
      wait_next = shifted[31:0];
    end
    age_last_next = (req_now > rd_entry.last_restart) ? req_now - rd_entry.last_restart : 64'd0;
    age_start_next = (req_now > rd_entry.started_at) ? req_now - rd_entry.started_at : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd <= command;
      req_idx <= rsb_pkg::SLOT_W'(slot);
      req_in_range <= (32'(slot) < 32'(rsb_pkg::SLOTS));
      req_now <= now_tick;
      req_want <= desired_run;
      req_policy <= policy;
      req_prog <= has_program;
      req_live <= context_live;
      req_cst <= context_status;
      req_part <= partition_present;
      rd_entry <= mem[rsb_pkg::SLOT_W'(slot)];
    end
    if (ctl.capture) begin
      ent <= rd_entry;
      ent_active <= req_in_range && active[req_idx];
      wait_ticks <= wait_next;
      age_last <= age_last_next;
      age_start <= age_start_next;
    end
    if (ctl.commit && mem_we) begin
      mem[req_idx] <= ent_next;
    end
    if (ctl.commit) begin
      action <= action_next;
      status <= status_next;
      restart_count_out <= report ? ent_next.retry_count : 8'd0;
      restarts_total_out <= report ? ent_next.retry_total : 32'd0;
      gave_up_out <= report && ent_next.gave_up;
      converged_out <= report && ent_next.converged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (ctl.commit) begin
      if (set_active) begin
        active[req_idx] <= 1'b1;
      end else if (clr_active) begin
        active[req_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    ent_next = ent;
    mem_we = 1'b0;
    set_active = 1'b0;
    clr_active = 1'b0;
    action_next = rsb_pkg::ACT_NONE;
    status_next = 1'b0;
    report = 1'b0;
    took = 1'b0;
    failure = (req_cst != rsb_pkg::CST_HALTED);
    wants_restart = (ent.policy == rsb_pkg::POL_ALWAYS) ||
                    ((ent.policy == rsb_pkg::POL_ON_FAILURE) && failure);
    backoff_ok = (ent.last_restart == 64'd0) || (age_last >= {32'd0, wait_ticks});
    stable_ok = age_start >= {32'd0, cfg.stable_reset_ticks};
    unique case (req_cmd)
      rsb_pkg::CMD_DECLARE, rsb_pkg::CMD_REDECLARE: begin
        if (!req_in_range) begin
          status_next = 1'b1;
        end else begin
          if (req_cmd == rsb_pkg::CMD_DECLARE || !ent_active) begin
            ent_next.retry_total = 32'd0;
            ent_next.last_restart = 64'd0;
            ent_next.started_at = 64'd0;
          end
          ent_next.desired_running = req_want;
          ent_next.has_program = req_prog;
          ent_next.policy = (req_policy == rsb_pkg::POL_ON_FAILURE ||
                             req_policy == rsb_pkg::POL_ALWAYS) ?
                            req_policy : rsb_pkg::POL_NEVER;
          ent_next.gave_up = 1'b0;
          ent_next.retry_count = 8'd0;
          ent_next.converged = 1'b0;
          mem_we = 1'b1;
          set_active = 1'b1;
          report = 1'b1;
        end
      end
      rsb_pkg::CMD_CLEAR_GIVE_UP: begin
        if (!ent_active) begin
          status_next = 1'b1;
        end else begin
          ent_next.gave_up = 1'b0;
          ent_next.retry_count = 8'd0;
          mem_we = 1'b1;
          report = 1'b1;
        end
      end
      rsb_pkg::CMD_DELETE: begin
        if (!ent_active) begin
          status_next = 1'b1;
        end else begin
          clr_active = 1'b1;
          report = 1'b1;
        end
      end
      rsb_pkg::CMD_EVALUATE: begin
        if (!ent_active) begin
          status_next = 1'b1;
        end else if (cfg.enable) begin
          report = 1'b1;
          mem_we = 1'b1;
          if (!req_part) begin
            ent_next.converged = 1'b0;
          end else begin
            if (ent.has_program) begin
              if (ent.desired_running && !req_live) begin
                ent_next.started_at = req_now;
                action_next = rsb_pkg::ACT_START;
                took = 1'b1;
              end else if (ent.desired_running && req_live) begin
                if (req_cst == rsb_pkg::CST_RUNNING) begin
                  if (ent.retry_count != 8'd0 && ent.started_at != 64'd0 && stable_ok) begin
                    ent_next.retry_count = 8'd0;
                  end
                end else if (req_cst != rsb_pkg::CST_UNKNOWN && !ent.gave_up && wants_restart) begin
                  if (ent.retry_count >= cfg.max_attempts) begin
                    ent_next.gave_up = 1'b1;
                    action_next = rsb_pkg::ACT_GAVE_UP;
                  end else if (backoff_ok) begin
                    ent_next.retry_count = ent.retry_count + 8'd1;
                    ent_next.retry_total = ent.retry_total + 32'd1;
                    ent_next.last_restart = req_now;
                    ent_next.started_at = req_now;
                    action_next = rsb_pkg::ACT_RESTART;
                    took = 1'b1;
                  end
                end
              end else if (!ent.desired_running && req_live) begin
                action_next = rsb_pkg::ACT_STOP;
                took = 1'b1;
              end
            end
            ent_next.converged = !took;
          end
        end else begin
          report = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/restart_supervisor_backoff.sv @@
// Channel   Handshake                  Payload
// request   start in, busy out         command, slot, now_tick, desired_run, policy,
//                                      has_program, context_live, context_status,
//                                      partition_present
// result    done out, one cycle        action, status, restart_count_out,
//                                      restarts_total_out, gave_up_out, converged_out
// config    cfg_valid in, cfg_ready    cfg_index, cfg_data
//
// A request steps through states: the accepting cycle reads the slot table, ST_READ
// registers the stamp ages and the backoff wait, and ST_EXEC decides and writes back.
// The result is strobed by done in the cycle after, when a new request may be accepted.
// Reset clears the active bits and the control and configuration registers, not the
// slot table. Results cannot be stalled; configuration writes are always ready.
module restart_supervisor_backoff (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [2:0] command,
  input  logic [3:0] slot,
  input  logic [63:0] now_tick,
  input  logic desired_run,
  input  logic [1:0] policy,
  input  logic has_program,
  input  logic context_live,
  input  logic [1:0] context_status,
  input  logic partition_present,
  output logic done,
  output logic [2:0] action,
  output logic status,
  output logic [7:0] restart_count_out,
  output logic [31:0] restarts_total_out,
  output logic gave_up_out,
  output logic converged_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  rsb_pkg::cfg_t cfg;
  rsb_pkg::ctrl_cmd_t ctl;

  rsb_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  rsb_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .ctl(ctl)
  );

  rsb_dpath u_dpath (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .cfg(cfg),
    .command(command),
    .slot(slot),
    .now_tick(now_tick),
    .desired_run(desired_run),
    .policy(policy),
    .has_program(has_program),
    .context_live(context_live),
    .context_status(context_status),
    .partition_present(partition_present),
    .action(action),
    .status(status),
    .restart_count_out(restart_count_out),
    .restarts_total_out(restarts_total_out),
    .gave_up_out(gave_up_out),
    .converged_out(converged_out)
  );

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("request result not delivered three cycles after acceptance");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without a request in progress");

  a_inactive_result_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (action == rsb_pkg::ACT_NONE && restart_count_out == 8'd0 &&
                          restarts_total_out == 32'd0 && !gave_up_out && !converged_out))
    else $error("result for an inactive slot carries slot fields");

  a_converged_no_action: assert property (@(posedge clk) disable iff (rst)
    (done && converged_out) |-> (action != rsb_pkg::ACT_START &&
                                 action != rsb_pkg::ACT_RESTART &&
                                 action != rsb_pkg::ACT_STOP))
    else $error("converged result reports a start, restart or stop");

endmodule

@@ sim/restart_supervisor_backoff_tb.sv @@
`timescale 1ns / 100ps

module restart_supervisor_backoff_tb;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 228;
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam logic [1:0] POL_UNDEFINED = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] slot;
    logic [63:0] now_tick;
    logic desired_run;
    logic [1:0] policy;
    logic has_program;
    logic context_live;
    logic [1:0] context_status;
    logic partition_present;
  } request_t;

  typedef struct packed {
    logic [2:0] act;
    logic stat;
    logic [7:0] count;
    logic [31:0] total;
    logic gave_up;
    logic converged;
  } result_t;

  typedef struct packed {
    logic en;
    logic [31:0] base;
    logic [31:0] cap;
    logic [31:0] stable;
    logic [7:0] attempts;
    int unsigned step;
    logic idle_on;
  } phase_t;

  class slot_scoreboard;
    bit en;
    bit [31:0] base_ticks;
    bit [31:0] cap_ticks;
    bit [31:0] stable_ticks;
    bit [7:0] attempts;
    bit s_active[rsb_pkg::SLOTS];
    bit s_run[rsb_pkg::SLOTS];
    rsb_pkg::policy_t s_policy[rsb_pkg::SLOTS];
    bit s_program[rsb_pkg::SLOTS];
    bit [7:0] s_count[rsb_pkg::SLOTS];
    bit [31:0] s_total[rsb_pkg::SLOTS];
    bit [63:0] s_last[rsb_pkg::SLOTS];
    bit [63:0] s_started[rsb_pkg::SLOTS];
    bit s_gave_up[rsb_pkg::SLOTS];
    bit s_converged[rsb_pkg::SLOTS];
    result_t expected_results[$];
    int errors;

    function new();
      en = 1'b0;
      base_ticks = rsb_pkg::RESET_BACKOFF_BASE;
      cap_ticks = rsb_pkg::RESET_BACKOFF_MAX;
      stable_ticks = rsb_pkg::RESET_STABLE_TICKS;
      attempts = rsb_pkg::RESET_MAX_ATTEMPTS;
      errors = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        rsb_pkg::REG_ENABLE: en = data[0];
        rsb_pkg::REG_BACKOFF_BASE: base_ticks = data;
        rsb_pkg::REG_BACKOFF_MAX: cap_ticks = data;
        rsb_pkg::REG_STABLE_RESET: stable_ticks = data;
        rsb_pkg::REG_MAX_ATTEMPTS: attempts = data[7:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] age(bit [63:0] now, bit [63:0] stamp);
      return (now > stamp) ? now - stamp : 64'd0;
    endfunction

    function bit [63:0] backoff(bit [7:0] made);
      bit [63:0] b;
      bit [63:0] lim;
      b = base_ticks;
      lim = cap_ticks;
      for (int i = 1; i < made && b < lim; i++) b = b << 1;
      return (b > lim) ? lim : b;
    endfunction

    function result_t report(rsb_pkg::action_t verdict, bit stat, int s);
      result_t o;
      o = '0;
      o.act = verdict;
      o.stat = stat;
      if (s >= 0) begin
        o.count = s_count[s];
        o.total = s_total[s];
        o.gave_up = s_gave_up[s];
        o.converged = s_converged[s];
      end
      return o;
    endfunction

    function rsb_pkg::action_t evaluate_slot(int s, request_t r);
      rsb_pkg::action_t verdict;
      bit took;
      bit failure;
      bit wants;
      verdict = rsb_pkg::ACT_NONE;
      took = 1'b0;
      if (!r.partition_present) begin
        s_converged[s] = 1'b0;
        return rsb_pkg::ACT_NONE;
      end
      if (s_program[s]) begin
        if (s_run[s] && !r.context_live) begin
          s_started[s] = r.now_tick;
          verdict = rsb_pkg::ACT_START;
          took = 1'b1;
        end else if (s_run[s] && r.context_live) begin
          if (r.context_status == rsb_pkg::CST_RUNNING) begin
            if (s_count[s] > 0 && s_started[s] != 0 &&
                age(r.now_tick, s_started[s]) >= 64'(stable_ticks)) begin
              s_count[s] = 8'd0;
            end
          end else if (r.context_status != rsb_pkg::CST_UNKNOWN && !s_gave_up[s]) begin
            failure = (r.context_status != rsb_pkg::CST_HALTED);
            wants = (s_policy[s] == rsb_pkg::POL_ALWAYS) ||
                    (s_policy[s] == rsb_pkg::POL_ON_FAILURE && failure);
            if (wants) begin
              if (s_count[s] >= attempts) begin
                s_gave_up[s] = 1'b1;
                verdict = rsb_pkg::ACT_GAVE_UP;
              end else if (s_last[s] == 0 ||
                           age(r.now_tick, s_last[s]) >= backoff(s_count[s])) begin
                s_count[s]++;
                s_total[s]++;
                s_last[s] = r.now_tick;
                s_started[s] = r.now_tick;
                verdict = rsb_pkg::ACT_RESTART;
                took = 1'b1;
              end
            end
          end
        end else if (!s_run[s] && r.context_live) begin
          verdict = rsb_pkg::ACT_STOP;
          took = 1'b1;
        end
      end
      s_converged[s] = !took;
      return verdict;
    endfunction

    function void note_request(request_t r);
      int s;
      bit inrange;
      result_t o;
      rsb_pkg::action_t verdict;
      s = int'(r.slot);
      inrange = s < rsb_pkg::SLOTS;
      if (r.command > rsb_pkg::CMD_DELETE) begin
        o = report(rsb_pkg::ACT_NONE, 1'b0, -1);
      end else if (r.command == rsb_pkg::CMD_DECLARE ||
                   r.command == rsb_pkg::CMD_REDECLARE) begin
        if (!inrange) begin
          o = report(rsb_pkg::ACT_NONE, 1'b1, -1);
        end else begin
          if (r.command == rsb_pkg::CMD_DECLARE || !s_active[s]) begin
            s_active[s] = 1'b1;
            s_total[s] = '0;
            s_last[s] = '0;
            s_started[s] = '0;
          end
          s_run[s] = r.desired_run;
          s_program[s] = r.has_program;
          s_policy[s] = (r.policy == rsb_pkg::POL_ON_FAILURE ||
                         r.policy == rsb_pkg::POL_ALWAYS) ?
                        rsb_pkg::policy_t'(r.policy) : rsb_pkg::POL_NEVER;
          s_gave_up[s] = 1'b0;
          s_count[s] = 8'd0;
          s_converged[s] = 1'b0;
          o = report(rsb_pkg::ACT_NONE, 1'b0, s);
        end
      end else if (!inrange || !s_active[s]) begin
        o = report(rsb_pkg::ACT_NONE, 1'b1, -1);
      end else if (r.command == rsb_pkg::CMD_CLEAR_GIVE_UP) begin
        s_gave_up[s] = 1'b0;
        s_count[s] = 8'd0;
        o = report(rsb_pkg::ACT_NONE, 1'b0, s);
      end else if (r.command == rsb_pkg::CMD_DELETE) begin
        s_active[s] = 1'b0;
        o = report(rsb_pkg::ACT_NONE, 1'b0, s);
      end else if (!en) begin
        o = report(rsb_pkg::ACT_NONE, 1'b0, s);
      end else begin
        verdict = evaluate_slot(s, r);
        o = report(verdict, 1'b0, s);
      end
      expected_results.push_back(o);
    endfunction

    function void compare(string field, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result strobed with no request outstanding");
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare("action", exp_r.act, got.act);
      compare("status", exp_r.stat, got.stat);
      compare("restart_count_out", exp_r.count, got.count);
      compare("restarts_total_out", exp_r.total, got.total);
      compare("gave_up_out", exp_r.gave_up, got.gave_up);
      compare("converged_out", exp_r.converged, got.converged);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] command;
  logic [3:0] slot;
  logic [63:0] now_tick;
  logic desired_run;
  logic [1:0] policy;
  logic has_program;
  logic context_live;
  logic [1:0] context_status;
  logic partition_present;
  logic done;
  logic [2:0] action;
  logic status;
  logic [7:0] restart_count_out;
  logic [31:0] restarts_total_out;
  logic gave_up_out;
  logic converged_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  slot_scoreboard slots = new();
  int unsigned stall_cycles;
  logic [63:0] tick_now;
  int unsigned tick_step;

  restart_supervisor_backoff u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .slot(slot),
    .now_tick(now_tick),
    .desired_run(desired_run),
    .policy(policy),
    .has_program(has_program),
    .context_live(context_live),
    .context_status(context_status),
    .partition_present(partition_present),
    .done(done),
    .action(action),
    .status(status),
    .restart_count_out(restart_count_out),
    .restarts_total_out(restarts_total_out),
    .gave_up_out(gave_up_out),
    .converged_out(converged_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    result_t seen;
    if (!rst && done) begin
      seen.act = action;
      seen.stat = status;
      seen.count = restart_count_out;
      seen.total = restarts_total_out;
      seen.gave_up = gave_up_out;
      seen.converged = converged_out;
      slots.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic request_t make_eval(logic [3:0] s, logic [63:0] tick, logic live,
                                         logic [1:0] cst, logic part);
    request_t r;
    r = '0;
    r.command = rsb_pkg::CMD_EVALUATE;
    r.slot = s;
    r.now_tick = tick;
    r.context_live = live;
    r.context_status = cst;
    r.partition_present = part;
    return r;
  endfunction

  function automatic request_t make_decl(logic [2:0] cmd, logic [3:0] s, logic run,
                                         logic [1:0] pol, logic prog);
    request_t r;
    r = '0;
    r.command = cmd;
    r.slot = s;
    r.desired_run = run;
    r.policy = pol;
    r.has_program = prog;
    return r;
  endfunction

  function automatic request_t make_cmd(logic [2:0] cmd, logic [3:0] s);
    request_t r;
    r = '0;
    r.command = cmd;
    r.slot = s;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.slot = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) :
                                           4'($urandom_range(0, 15));
    r.desired_run = ($urandom_range(0, 4) != 0);
    r.policy = 2'($urandom_range(0, 3));
    r.has_program = ($urandom_range(0, 6) != 0);
    r.context_live = ($urandom_range(0, 3) != 0);
    r.partition_present = ($urandom_range(0, 11) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) r.context_status = rsb_pkg::CST_TRAPPED;
    else if (pick < 65) r.context_status = rsb_pkg::CST_HALTED;
    else if (pick < 92) r.context_status = rsb_pkg::CST_RUNNING;
    else r.context_status = rsb_pkg::CST_UNKNOWN;
    tick_now = tick_now + $urandom_range(0, tick_step);
    pick = $urandom_range(0, 99);
    if (pick < 6) r.now_tick = {$urandom, $urandom};
    else if (pick < 7) r.now_tick = '0;
    else if (pick < 8) r.now_tick = '1;
    else r.now_tick = tick_now;
    pick = $urandom_range(0, 99);
    if (pick < 68) r.command = rsb_pkg::CMD_EVALUATE;
    else if (pick < 76) r.command = rsb_pkg::CMD_DECLARE;
    else if (pick < 83) r.command = rsb_pkg::CMD_REDECLARE;
    else if (pick < 89) r.command = rsb_pkg::CMD_CLEAR_GIVE_UP;
    else if (pick < 95) r.command = rsb_pkg::CMD_DELETE;
    else r.command = 3'($urandom_range(int'(rsb_pkg::CMD_DELETE) + 1, int'(CMD_UNKNOWN)));
    return r;
  endfunction

  task automatic push_request(input request_t r);
    start <= 1'b1;
    command <= r.command;
    slot <= r.slot;
    now_tick <= r.now_tick;
    desired_run <= r.desired_run;
    policy <= r.policy;
    has_program <= r.has_program;
    context_live <= r.context_live;
    context_status <= r.context_status;
    partition_present <= r.partition_present;
    @(posedge clk);
    while (busy) @(posedge clk);
    slots.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (slots.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [31:0] data);
    if ($urandom_range(0, 99) < 32) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slots.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input phase_t c);
    set_register(rsb_pkg::REG_MAX_ATTEMPTS, 32'(c.attempts));
    set_register(rsb_pkg::REG_BACKOFF_BASE, c.base);
    set_register(rsb_pkg::REG_STABLE_RESET, c.stable);
    set_register(rsb_pkg::REG_BACKOFF_MAX, c.cap);
    set_register(rsb_pkg::REG_ENABLE, 32'(c.en));
    cfg_valid <= 1'b0;
    @(negedge clk);
    tick_step = c.step;
  endtask

  initial begin
    phase_t plan[8];
    phase_t opening;
    request_t directed[$];
    rst <= 1'b1;
    start <= 1'b0;
    command <= rsb_pkg::CMD_EVALUATE;
    slot <= '0;
    now_tick <= '0;
    desired_run <= 1'b0;
    policy <= rsb_pkg::POL_NEVER;
    has_program <= 1'b0;
    context_live <= 1'b0;
    context_status <= rsb_pkg::CST_RUNNING;
    partition_present <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= rsb_pkg::REG_ENABLE;
    cfg_data <= '0;
    tick_now = 64'd5000;
    tick_step = 10;

    opening = '{1'b1, 32'd4, 32'd16, 32'd50, 8'd3, 12, 1'b1};
    plan[0] = '{1'b1, 32'd4, 32'd16, 32'd50, 8'd3, 12, 1'b1};
    plan[1] = '{1'b1, 32'd1, 32'd1, 32'd1, 8'd0, 3, 1'b1};
    plan[2] = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1000, 1'b1};
    plan[3] = '{1'b1, 32'd0, 32'd8, 32'd20, 8'd5, 6, 1'b1};
    plan[4] = '{1'b0, 32'd10, 32'd100, 32'd100, 8'd4, 50, 1'b1};
    plan[5] = '{1'b1, 32'd3, 32'd1000, 32'd200, 8'd8, 60, 1'b0};
    plan[6] = '{1'b1, rsb_pkg::RESET_BACKOFF_BASE, rsb_pkg::RESET_BACKOFF_MAX,
                rsb_pkg::RESET_STABLE_TICKS, rsb_pkg::RESET_MAX_ATTEMPTS, 2000, 1'b1};
    plan[7] = '{1'b1, 32'($urandom_range(1, 64)), 32'($urandom_range(64, 4096)),
                32'($urandom_range(1, 3000)), 8'($urandom_range(0, 12)), 100, 1'b1};

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_request(make_decl(rsb_pkg::CMD_DECLARE, 4'd5, 1'b1, rsb_pkg::POL_ALWAYS, 1'b1));
    push_request(make_eval(4'd5, 64'd900, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    push_request(make_eval(4'd9, 64'd900, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    drain_results();
    set_register(REG_UNUSED, 32'hFFFF_FFFF);
    configure(opening);

    directed.push_back(make_eval(4'd0, 64'd1000, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_cmd(rsb_pkg::CMD_DELETE, 4'd2));
    directed.push_back(make_cmd(rsb_pkg::CMD_CLEAR_GIVE_UP, 4'd1));
    directed.push_back(make_decl(rsb_pkg::CMD_DECLARE, 4'd0, 1'b1, rsb_pkg::POL_ALWAYS, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1000, 1'b0, rsb_pkg::CST_RUNNING, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1001, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1002, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1010, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1100, 1'b1, rsb_pkg::CST_HALTED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1200, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1300, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_cmd(rsb_pkg::CMD_CLEAR_GIVE_UP, 4'd0));
    directed.push_back(make_decl(rsb_pkg::CMD_DECLARE, 4'd1, 1'b0, POL_UNDEFINED, 1'b1));
    directed.push_back(make_eval(4'd1, 64'd1500, 1'b1, rsb_pkg::CST_RUNNING, 1'b1));
    directed.push_back(make_eval(4'd1, 64'd1501, 1'b1, rsb_pkg::CST_RUNNING, 1'b0));
    directed.push_back(make_decl(rsb_pkg::CMD_REDECLARE, 4'd0, 1'b1,
                                 rsb_pkg::POL_ON_FAILURE, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1600, 1'b1, rsb_pkg::CST_HALTED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1601, 1'b1, rsb_pkg::CST_UNKNOWN, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd0, 1'b0, rsb_pkg::CST_RUNNING, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1700, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_eval(4'd0, 64'd1800, 1'b1, rsb_pkg::CST_RUNNING, 1'b1));
    directed.push_back(make_cmd(rsb_pkg::CMD_DELETE, 4'd0));
    directed.push_back(make_eval(4'd0, 64'd1900, 1'b1, rsb_pkg::CST_TRAPPED, 1'b1));
    directed.push_back(make_decl(rsb_pkg::CMD_REDECLARE, 4'd0, 1'b1,
                                 rsb_pkg::POL_ALWAYS, 1'b1));
    directed.push_back(make_cmd(CMD_UNKNOWN, 4'd0));
    directed.push_back(make_eval(4'd0, '1, 1'b0, rsb_pkg::CST_RUNNING, 1'b1));
    foreach (directed[k]) push_request(directed[k]);

    foreach (plan[p]) begin
      drain_results();
      configure(plan[p]);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        while (plan[p].idle_on && $urandom_range(0, 99) < 32) begin
          start <= 1'b0;
          @(negedge clk);
        end
        if ($urandom_range(0, 99) == 0) drain_results();
        push_request(random_request());
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (slots.errors == 0 && slots.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
